// ----- rtl/ftra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftra_pkg
// Shared types, widths and constants of the tridiagonal row assembler.
// ----------------------------------------------------------------------------
package ftra_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int OUT_W     = 64;
    localparam int SPAN_W    = DATA_W + 1;
    localparam int WGT_W     = DATA_W + 6;
    localparam int PROD_W    = SPAN_W + WGT_W;
    localparam int DEN_W     = 7;
    localparam int RDIV_W    = DATA_W + FRAC_BITS;
    localparam int RCNT_W    = $clog2(RDIV_W + 1);
    localparam int MCNT_W    = $clog2(PROD_W + 1);

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_RATIO = 2'd1;
    localparam logic [1:0] MODE_COEF  = 2'd2;

    localparam logic [DEN_W-1:0] DEN_PLAIN = DEN_W'(6);
    localparam logic [DEN_W-1:0] DEN_RATIO = DEN_W'(60);
    localparam logic [DEN_W-1:0] DEN_COEF  = DEN_W'(12);

    localparam logic [1:0] ENT_LEFT  = 2'd0;
    localparam logic [1:0] ENT_OFF   = 2'd1;
    localparam logic [1:0] ENT_RIGHT = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] node_position;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] divisor_value;
        logic                     last_node;
    } t_node_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] sub_entry;
        logic signed [OUT_W-1:0] diag_entry;
        logic signed [OUT_W-1:0] super_entry;
        logic                    row_last;
        logic                    divide_error;
    } t_row_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RQ_GO,
        ST_RQ_WAIT,
        ST_RQP_GO,
        ST_RQP_WAIT,
        ST_RPQ_GO,
        ST_RPQ_WAIT,
        ST_ENT_GO,
        ST_ENT_WAIT,
        ST_ROW1,
        ST_ROW2
    } t_state;

    function automatic logic signed [WGT_W-1:0] sx_w(input logic signed [DATA_W-1:0] x);
        sx_w = {{(WGT_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

endpackage

// ----- rtl/ftra_ratio_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftra_ratio_div
// Bit-serial signed Q ratio a * 2^F / v with truncation and saturation.
// ----------------------------------------------------------------------------
module ftra_ratio_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ftra_pkg::DATA_W-1:0]   i_coef,
    input  logic signed [ftra_pkg::DATA_W-1:0]   i_divisor,
    output logic                                 o_done,
    output logic signed [ftra_pkg::DATA_W-1:0]   o_ratio,
    output logic                                 o_fault
);

    localparam int DW = ftra_pkg::DATA_W;
    localparam int QW = ftra_pkg::RDIV_W;

    logic                          r_busy, r_done, r_neg, r_zero, r_coef_zero;
    logic [ftra_pkg::RCNT_W-1:0]   r_cnt;
    logic [DW-1:0]                 r_rem, r_dvs;
    logic [QW-1:0]                 r_quo;

    logic [DW-1:0] abs_a, abs_v;
    logic [DW:0]   shifted;
    logic          ge;
    logic          sat_pos, sat_neg, sat;

    assign abs_a   = i_coef[DW-1] ? (~i_coef + 1'b1) : i_coef;
    assign abs_v   = i_divisor[DW-1] ? (~i_divisor + 1'b1) : i_divisor;
    assign shifted = {r_rem, r_quo[QW-1]};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy      <= 1'b1;
                r_cnt       <= ftra_pkg::RCNT_W'(QW);
                r_rem       <= '0;
                r_dvs       <= abs_v;
                r_quo       <= {abs_a, {ftra_pkg::FRAC_BITS{1'b0}}};
                r_neg       <= i_coef[DW-1] ^ i_divisor[DW-1];
                r_zero      <= (i_divisor == '0);
                r_coef_zero <= (i_coef == '0);
            end else if (r_busy) begin
                r_rem <= ge ? DW'(shifted - {1'b0, r_dvs}) : shifted[DW-1:0];
                r_quo <= {r_quo[QW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ftra_pkg::RCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sat_pos = |r_quo[QW-1:DW-1];
    assign sat_neg = (|r_quo[QW-1:DW]) || (r_quo[DW-1] && (|r_quo[DW-2:0]));
    assign sat     = r_neg ? sat_neg : sat_pos;
    assign o_done  = r_done;
    assign o_fault = r_zero || sat;

    always_comb begin
        if (r_zero) begin
            if (r_coef_zero) begin
                o_ratio = '0;
            end else begin
                o_ratio = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end
        end else if (sat) begin
            o_ratio = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            o_ratio = r_neg ? (~r_quo[DW-1:0] + 1'b1) : r_quo[DW-1:0];
        end
    end

endmodule

// ----- rtl/ftra_mul_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftra_mul_div
// Bit-serial h * w / D with truncation toward zero, saturated to 64 bits.
// ----------------------------------------------------------------------------
module ftra_mul_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [ftra_pkg::SPAN_W-1:0]    i_span,
    input  logic signed [ftra_pkg::WGT_W-1:0]     i_weight,
    input  logic        [ftra_pkg::DEN_W-1:0]     i_denom,
    output logic                                  o_done,
    output logic signed [ftra_pkg::OUT_W-1:0]     o_entry
);

    localparam int SW = ftra_pkg::SPAN_W;
    localparam int WW = ftra_pkg::WGT_W;
    localparam int PW = ftra_pkg::PROD_W;
    localparam int NW = ftra_pkg::DEN_W;
    localparam int OW = ftra_pkg::OUT_W;

    logic                          r_mul, r_div, r_done, r_neg;
    logic [ftra_pkg::MCNT_W-1:0]   r_cnt;
    logic [PW-1:0]                 r_acc, r_mcand;
    logic [SW-1:0]                 r_mplier;
    logic [NW-1:0]                 r_rem, r_den;

    logic [SW-1:0] abs_h;
    logic [WW-1:0] abs_w;
    logic [NW-1:0] shifted;
    logic          ge, sat;

    assign abs_h   = i_span[SW-1] ? (~i_span + 1'b1) : i_span;
    assign abs_w   = i_weight[WW-1] ? (~i_weight + 1'b1) : i_weight;
    assign shifted = {r_rem[NW-2:0], r_acc[PW-1]};
    assign ge      = shifted >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mul    <= 1'b1;
                r_div    <= 1'b0;
                r_cnt    <= ftra_pkg::MCNT_W'(SW);
                r_acc    <= '0;
                r_mcand  <= PW'(abs_w);
                r_mplier <= abs_h;
                r_den    <= i_denom;
                r_neg    <= i_span[SW-1] ^ i_weight[WW-1];
            end else if (r_mul) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SW-1:1]};
                r_cnt    <= r_cnt - 1'b1;
                if (r_cnt == ftra_pkg::MCNT_W'(1)) begin
                    r_mul <= 1'b0;
                    r_div <= 1'b1;
                    r_cnt <= ftra_pkg::MCNT_W'(PW);
                    r_rem <= '0;
                end
            end else if (r_div) begin
                r_rem <= ge ? (shifted - r_den) : shifted;
                r_acc <= {r_acc[PW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ftra_pkg::MCNT_W'(1)) begin
                    r_div  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sat    = |r_acc[PW-1:OW-1];
    assign o_done = r_done;

    always_comb begin
        if (sat) begin
            o_entry = r_neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end else begin
            o_entry = r_neg ? (~r_acc[OW-1:0] + 1'b1) : r_acc[OW-1:0];
        end
    end

endmodule

// ----- rtl/fem_tridiagonal_row_assembler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fem_tridiagonal_row_assembler_core
// Builds tridiagonal mass matrix rows of a 1D linear finite element mesh.
//
//   channel  dir  handshake                    word
//   node     in   i_in_valid / o_in_stall      t_node_word
//   row      out  o_out_valid / i_out_stall    t_row_word
//   mode     in   i_cfg_valid / o_cfg_ready    matrix_mode[1:0]
//
// One node at a time. A node gets its own ratio from the serial ratio
// divider, two cross ratios more in mode 1, and then three entries from
// the serial multiply / divide unit before a row is emitted.
// Synchronous active-low reset clears control and carried state only. A
// held row stalls only the row emit step; the next node is taken while
// the last row waits.
// ----------------------------------------------------------------------------
module fem_tridiagonal_row_assembler_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ftra_pkg::t_node_word   i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ftra_pkg::t_row_word    o_out_word,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_data
);

    localparam int DW = ftra_pkg::DATA_W;
    localparam int OW = ftra_pkg::OUT_W;
    localparam int WW = ftra_pkg::WGT_W;

    ftra_pkg::t_state r_state, n_state;
    logic [1:0]        r_mode;

    ftra_pkg::t_node_word r_in;
    logic                 r_have;
    logic signed [DW-1:0] r_prev_pos, r_prev_coef, r_prev_div, r_prev_ratio;
    logic                 r_prev_fault;
    logic signed [OW-1:0] r_pend_sub, r_pend_diag;
    logic                 r_pend_err;
    logic signed [DW-1:0] r_rq, r_rqp, r_rpq;
    logic                 r_fq, r_f1, r_f2;
    logic signed [OW-1:0] r_dl, r_do, r_dr;
    logic [1:0]           r_ent;
    ftra_pkg::t_row_word  r_out;
    logic                 r_out_valid;

    logic                 accept, out_free, row_load;
    logic                 rd_start, rd_done, rd_fault;
    logic signed [DW-1:0] rd_coef, rd_div, rd_ratio;
    logic                 md_start, md_done;
    logic signed [OW-1:0] md_entry;
    logic signed [ftra_pkg::SPAN_W-1:0] span;
    logic signed [WW-1:0] wl, wo, wr, w_sel;
    logic signed [WW-1:0] xpp, xqp, xpq, xqq, ca, cb;
    logic [ftra_pkg::DEN_W-1:0] denom;
    logic                 row_err;
    logic signed [OW-1:0] diag_sum, diag_sat;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ftra_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign row_load    = ((r_state == ftra_pkg::ST_ROW1) || (r_state == ftra_pkg::ST_ROW2))
                       && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign span = {r_in.node_position[DW-1], r_in.node_position}
                - {r_prev_pos[DW-1], r_prev_pos};

    assign xpp = ftra_pkg::sx_w(r_prev_ratio);
    assign xqp = ftra_pkg::sx_w(r_rqp);
    assign xpq = ftra_pkg::sx_w(r_rpq);
    assign xqq = ftra_pkg::sx_w(r_rq);
    assign ca  = ftra_pkg::sx_w(r_prev_coef);
    assign cb  = ftra_pkg::sx_w(r_in.coef_value);

    always_comb begin
        case (r_mode)
            ftra_pkg::MODE_RATIO: begin
                wl = (xpp <<< 3) + (xpp <<< 2) + (xqp <<< 1) + xqp
                   + (xpq <<< 1) + xpq + (xqq <<< 1);
                wo = (xpp <<< 1) + xpp + (xqp <<< 1) + (xpq <<< 1)
                   + (xqq <<< 1) + xqq;
                wr = (xpp <<< 1) + (xqp <<< 1) + xqp + (xpq <<< 1) + xpq
                   + (xqq <<< 3) + (xqq <<< 2);
                denom = ftra_pkg::DEN_RATIO;
            end
            ftra_pkg::MODE_COEF: begin
                wl = (ca <<< 1) + ca + cb;
                wo = ca + cb;
                wr = ca + (cb <<< 1) + cb;
                denom = ftra_pkg::DEN_COEF;
            end
            default: begin
                wo = WW'(1) <<< ftra_pkg::FRAC_BITS;
                wl = WW'(1) <<< (ftra_pkg::FRAC_BITS + 1);
                wr = WW'(1) <<< (ftra_pkg::FRAC_BITS + 1);
                denom = ftra_pkg::DEN_PLAIN;
            end
        endcase
        case (r_ent)
            ftra_pkg::ENT_LEFT: w_sel = wl;
            ftra_pkg::ENT_OFF:  w_sel = wo;
            default:            w_sel = wr;
        endcase
    end

    assign row_err  = (r_mode == ftra_pkg::MODE_RATIO)
                    && (r_prev_fault || r_f1 || r_f2 || r_fq);
    assign diag_sum = r_pend_diag + r_dl;
    always_comb begin
        if (r_pend_diag[OW-1] == r_dl[OW-1] && diag_sum[OW-1] != r_pend_diag[OW-1]) begin
            diag_sat = r_pend_diag[OW-1] ? {1'b1, {(OW-1){1'b0}}}
                                         : {1'b0, {(OW-1){1'b1}}};
        end else begin
            diag_sat = diag_sum;
        end
    end

    always_comb begin
        case (r_state)
            ftra_pkg::ST_RQP_GO: begin
                rd_coef = r_in.coef_value;
                rd_div  = r_prev_div;
            end
            ftra_pkg::ST_RPQ_GO: begin
                rd_coef = r_prev_coef;
                rd_div  = r_in.divisor_value;
            end
            default: begin
                rd_coef = r_in.coef_value;
                rd_div  = r_in.divisor_value;
            end
        endcase
    end

    assign rd_start = (r_state == ftra_pkg::ST_RQ_GO) || (r_state == ftra_pkg::ST_RQP_GO)
                   || (r_state == ftra_pkg::ST_RPQ_GO);
    assign md_start = (r_state == ftra_pkg::ST_ENT_GO);

    ftra_ratio_div u_ratio (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rd_start),
        .i_coef    (rd_coef),
        .i_divisor (rd_div),
        .o_done    (rd_done),
        .o_ratio   (rd_ratio),
        .o_fault   (rd_fault)
    );

    ftra_mul_div u_entry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (md_start),
        .i_span   (span),
        .i_weight (w_sel),
        .i_denom  (denom),
        .o_done   (md_done),
        .o_entry  (md_entry)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ftra_pkg::ST_IDLE:     if (accept) n_state = ftra_pkg::ST_RQ_GO;
            ftra_pkg::ST_RQ_GO:    n_state = ftra_pkg::ST_RQ_WAIT;
            ftra_pkg::ST_RQ_WAIT: begin
                if (rd_done) begin
                    if (!r_have) begin
                        n_state = ftra_pkg::ST_IDLE;
                    end else if (r_mode == ftra_pkg::MODE_RATIO) begin
                        n_state = ftra_pkg::ST_RQP_GO;
                    end else begin
                        n_state = ftra_pkg::ST_ENT_GO;
                    end
                end
            end
            ftra_pkg::ST_RQP_GO:   n_state = ftra_pkg::ST_RQP_WAIT;
            ftra_pkg::ST_RQP_WAIT: if (rd_done) n_state = ftra_pkg::ST_RPQ_GO;
            ftra_pkg::ST_RPQ_GO:   n_state = ftra_pkg::ST_RPQ_WAIT;
            ftra_pkg::ST_RPQ_WAIT: if (rd_done) n_state = ftra_pkg::ST_ENT_GO;
            ftra_pkg::ST_ENT_GO:   n_state = ftra_pkg::ST_ENT_WAIT;
            ftra_pkg::ST_ENT_WAIT: begin
                if (md_done) begin
                    n_state = (r_ent == ftra_pkg::ENT_RIGHT) ? ftra_pkg::ST_ROW1
                                                             : ftra_pkg::ST_ENT_GO;
                end
            end
            ftra_pkg::ST_ROW1: begin
                if (out_free) begin
                    n_state = r_in.last_node ? ftra_pkg::ST_ROW2 : ftra_pkg::ST_IDLE;
                end
            end
            ftra_pkg::ST_ROW2:     if (out_free) n_state = ftra_pkg::ST_IDLE;
            default:               n_state = ftra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ftra_pkg::MODE_PLAIN;
            r_have       <= 1'b0;
            r_prev_pos   <= '0;
            r_prev_coef  <= '0;
            r_prev_div   <= '0;
            r_prev_ratio <= '0;
            r_prev_fault <= 1'b0;
            r_pend_sub   <= '0;
            r_pend_diag  <= '0;
            r_pend_err   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ent        <= ftra_pkg::ENT_LEFT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (row_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_in  <= i_in_word;
                r_f1  <= 1'b0;
                r_f2  <= 1'b0;
                r_rqp <= '0;
                r_rpq <= '0;
                r_ent <= ftra_pkg::ENT_LEFT;
            end
            case (r_state)
                ftra_pkg::ST_RQ_WAIT: begin
                    if (rd_done) begin
                        r_rq <= rd_ratio;
                        r_fq <= rd_fault;
                        if (!r_have && !r_in.last_node) begin
                            r_have       <= 1'b1;
                            r_prev_pos   <= r_in.node_position;
                            r_prev_coef  <= r_in.coef_value;
                            r_prev_div   <= r_in.divisor_value;
                            r_prev_ratio <= rd_ratio;
                            r_prev_fault <= rd_fault;
                            r_pend_sub   <= '0;
                            r_pend_diag  <= '0;
                            r_pend_err   <= 1'b0;
                        end
                    end
                end
                ftra_pkg::ST_RQP_WAIT: begin
                    if (rd_done) begin
                        r_rqp <= rd_ratio;
                        r_f1  <= rd_fault;
                    end
                end
                ftra_pkg::ST_RPQ_WAIT: begin
                    if (rd_done) begin
                        r_rpq <= rd_ratio;
                        r_f2  <= rd_fault;
                    end
                end
                ftra_pkg::ST_ENT_WAIT: begin
                    if (md_done) begin
                        case (r_ent)
                            ftra_pkg::ENT_LEFT: r_dl <= md_entry;
                            ftra_pkg::ENT_OFF:  r_do <= md_entry;
                            default:            r_dr <= md_entry;
                        endcase
                        r_ent <= r_ent + 1'b1;
                    end
                end
                ftra_pkg::ST_ROW1: begin
                    if (out_free) begin
                        r_out.sub_entry    <= r_pend_sub;
                        r_out.diag_entry   <= diag_sat;
                        r_out.super_entry  <= r_do;
                        r_out.row_last     <= 1'b0;
                        r_out.divide_error <= r_pend_err || row_err;
                        if (!r_in.last_node) begin
                            r_pend_sub   <= r_do;
                            r_pend_diag  <= r_dr;
                            r_pend_err   <= row_err;
                            r_prev_pos   <= r_in.node_position;
                            r_prev_coef  <= r_in.coef_value;
                            r_prev_div   <= r_in.divisor_value;
                            r_prev_ratio <= r_rq;
                            r_prev_fault <= r_fq;
                        end
                    end
                end
                ftra_pkg::ST_ROW2: begin
                    if (out_free) begin
                        r_out.sub_entry    <= r_do;
                        r_out.diag_entry   <= r_dr;
                        r_out.super_entry  <= '0;
                        r_out.row_last     <= 1'b1;
                        r_out.divide_error <= row_err;
                        r_have       <= 1'b0;
                        r_prev_pos   <= '0;
                        r_prev_coef  <= '0;
                        r_prev_div   <= '0;
                        r_prev_ratio <= '0;
                        r_prev_fault <= 1'b0;
                        r_pend_sub   <= '0;
                        r_pend_diag  <= '0;
                        r_pend_err   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
